>>> design/mcet_pkg.sv
// shared constants for the event timer core
package mcet_pkg;
    localparam int TABLE_DEPTH_DEF = 16;
    localparam int TICK_BITS_DEF   = 32;

    localparam logic [1:0] CMD_ADVANCE = 2'd0;
    localparam logic [1:0] CMD_CREATE  = 2'd1;
    localparam logic [1:0] CMD_CLEAR   = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic KIND_FIRE   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;
endpackage

>>> design/mcet_divider.sv
// restoring divider, one quotient bit per cycle
module mcet_divider #(
    parameter int W = mcet_pkg::TICK_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_num,
    input  logic [W-1:0] i_den,
    output logic         o_done,
    output logic [W-1:0] o_quo,
    output logic [W-1:0] o_rem
);
    localparam int CW = $clog2(W + 1);
    logic [W-1:0]  r_quo, r_rem, r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy, r_done;
    logic [W:0]    w_trial;

    assign w_trial = {r_rem, r_quo[W-1]} - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_quo  <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
                r_cnt  <= CW'(W);
            end else if (r_busy) begin
                if (!w_trial[W]) begin
                    r_rem <= w_trial[W-1:0];
                    r_quo <= {r_quo[W-2:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[W-2:0], r_quo[W-1]};
                    r_quo <= {r_quo[W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
endmodule

>>> design/multi_channel_event_timer_core.sv
// Event timer core. Holds up to TABLE_DEPTH timers in creation order in one
// synchronous table memory, read one entry per step through a registered port.
// Clear empties the table. Create scans the table for the id, then overwrites
// a match or appends a new timer. Advance walks every entry, sends an expiry
// report for each expired timer and uses the shared bit-serial divider for
// each expired periodic timer; results wait while the output stalls. One
// command is worked at a time; the next item is taken once the final status
// result is handed off.
module multi_channel_event_timer_core #(
    parameter int TABLE_DEPTH = mcet_pkg::TABLE_DEPTH_DEF,
    parameter int TICK_BITS   = mcet_pkg::TICK_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_cmd,
    input  logic [7:0]  i_timer_id,
    input  logic [31:0] i_duration_ticks,
    input  logic        i_is_repeating,
    input  logic [31:0] i_delta_ticks,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_kind,
    output logic [7:0]  o_fired_id,
    output logic [31:0] o_fired_duration,
    output logic        o_fired_repeating,
    output logic [31:0] o_fire_count,
    output logic [4:0]  o_timer_count,
    output logic [1:0]  o_status,
    output logic        o_last
);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int TW = TICK_BITS;
    localparam int DW = 8 + TW + TW + 1;
    localparam int DUR_IN = (TW < 32) ? TW : 32;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_WAIT, S_EXAM, S_DIV, S_EMIT, S_WB, S_CREATE, S_STATUS, S_OUT
    } t_state;

    logic [DW-1:0] mem [TABLE_DEPTH];
    logic [DW-1:0] r_rdata;

    t_state        r_state;
    logic [CW-1:0] r_count, r_idx, r_wp, r_hit;
    logic          r_found;
    logic [1:0]    r_cmd, r_st;
    logic [7:0]    r_id;
    logic [TW-1:0] r_dur, r_delta;
    logic          r_rep;
    logic          r_keep;
    logic [TW-1:0] r_e_rem;
    logic [TW:0]   r_cnt;
    logic          r_we;
    logic [AW-1:0] r_waddr;
    logic [DW-1:0] r_wdata;
    logic          r_div_go;

    logic          r_ov, r_okind, r_orep, r_olast;
    logic [7:0]    r_oid;
    logic [31:0]   r_odur, r_ofc;
    logic [4:0]    r_otc;
    logic [1:0]    r_ost;

    logic [7:0]    w_eid;
    logic [TW-1:0] w_edur, w_erem;
    logic          w_erep;
    logic          w_div_done;
    logic [TW-1:0] w_quo, w_rem;
    logic [TW-1:0] w_over;

    assign {w_eid, w_edur, w_erem, w_erep} = r_rdata;
    assign w_over = r_delta - w_erem;

    mcet_divider #(.W(TW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_div_go),
        .i_num(w_over), .i_den(w_edur),
        .o_done(w_div_done), .o_quo(w_quo), .o_rem(w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (r_we) mem[r_waddr] <= r_wdata;
        r_rdata <= mem[r_idx[AW-1:0]];
    end

    logic w_out_free;
    assign w_out_free = !r_ov || !i_stall;
    assign o_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ov     <= 1'b0;
            r_we     <= 1'b0;
            r_div_go <= 1'b0;
            r_idx    <= '0;
        end else begin
            r_we     <= 1'b0;
            r_div_go <= 1'b0;
            if (r_ov && !i_stall) r_ov <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cmd   <= i_cmd;
                        r_id    <= i_timer_id;
                        r_dur   <= TW'(i_duration_ticks[DUR_IN-1:0]);
                        r_rep   <= i_is_repeating;
                        r_delta <= TW'(i_delta_ticks[DUR_IN-1:0]);
                        r_st    <= mcet_pkg::ST_OK;
                        r_idx   <= '0;
                        r_wp    <= '0;
                        r_found <= 1'b0;
                        case (i_cmd)
                            mcet_pkg::CMD_ADVANCE: r_state <= S_RD;
                            mcet_pkg::CMD_CREATE: begin
                                if (i_duration_ticks[DUR_IN-1:0] == '0) begin
                                    r_st    <= mcet_pkg::ST_ZERO;
                                    r_state <= S_STATUS;
                                end else begin
                                    r_state <= S_RD;
                                end
                            end
                            mcet_pkg::CMD_CLEAR: begin
                                r_count <= '0;
                                r_state <= S_STATUS;
                            end
                            default: r_state <= S_STATUS;
                        endcase
                    end
                end
                S_RD: begin
                    // read issued for r_idx; a pending write-back lands at a lower address
                    if (r_idx >= r_count) begin
                        r_state <= (r_cmd == mcet_pkg::CMD_CREATE) ? S_CREATE : S_STATUS;
                        if (r_cmd == mcet_pkg::CMD_ADVANCE) r_count <= r_wp;
                    end else begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    r_state <= S_EXAM;
                end
                S_EXAM: begin
                    if (r_cmd == mcet_pkg::CMD_CREATE) begin
                        if (w_eid == r_id) begin
                            r_hit   <= r_idx;
                            r_found <= 1'b1;
                            r_state <= S_CREATE;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_RD;
                        end
                    end else if (r_delta >= w_erem) begin
                        if (w_erep && w_edur != '0) begin
                            r_div_go <= 1'b1;
                            r_state  <= S_DIV;
                        end else begin
                            r_keep  <= 1'b0;
                            r_cnt   <= (TW+1)'(1);
                            r_state <= S_EMIT;
                        end
                    end else begin
                        r_keep  <= 1'b1;
                        r_e_rem <= w_erem - r_delta;
                        r_state <= S_WB;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_keep  <= 1'b1;
                        r_cnt   <= {1'b0, w_quo} + 1'b1;
                        r_e_rem <= w_edur - w_rem;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_ov     <= 1'b1;
                        r_okind  <= mcet_pkg::KIND_FIRE;
                        r_oid    <= w_eid;
                        r_odur   <= 32'(w_edur);
                        r_orep   <= w_erep;
                        r_ofc    <= (r_cnt > (TW+1)'(33'hFFFF_FFFF)) ? 32'hFFFF_FFFF
                                                                     : 32'(r_cnt);
                        r_otc    <= '0;
                        r_ost    <= mcet_pkg::ST_OK;
                        r_olast  <= 1'b0;
                        r_state  <= S_WB;
                    end
                end
                S_WB: begin
                    if (r_keep) begin
                        r_we    <= 1'b1;
                        r_waddr <= r_wp[AW-1:0];
                        r_wdata <= {w_eid, w_edur, r_e_rem, w_erep};
                        r_wp    <= r_wp + 1'b1;
                    end
                    r_idx   <= r_idx + 1'b1;
                    r_state <= S_RD;
                end
                S_CREATE: begin
                    if (!r_found && r_count >= CW'(TABLE_DEPTH)) begin
                        r_st <= mcet_pkg::ST_FULL;
                    end else begin
                        r_we    <= 1'b1;
                        r_waddr <= r_found ? r_hit[AW-1:0] : r_count[AW-1:0];
                        r_wdata <= {r_id, r_dur, r_dur, r_rep};
                        if (!r_found) r_count <= r_count + 1'b1;
                    end
                    r_state <= S_STATUS;
                end
                S_STATUS: begin
                    if (w_out_free) begin
                        r_ov    <= 1'b1;
                        r_okind <= mcet_pkg::KIND_STATUS;
                        r_oid   <= '0;
                        r_odur  <= '0;
                        r_orep  <= 1'b0;
                        r_ofc   <= '0;
                        r_otc   <= 5'(r_count);
                        r_ost   <= r_st;
                        r_olast <= 1'b1;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_ov || !i_stall) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid           = r_ov;
    assign o_kind            = r_okind;
    assign o_fired_id        = r_oid;
    assign o_fired_duration  = r_odur;
    assign o_fired_repeating = r_orep;
    assign o_fire_count      = r_ofc;
    assign o_timer_count     = r_otc;
    assign o_status          = r_ost;
    assign o_last            = r_olast;
endmodule

>>> design/mcet_checker.sv
// port-level checks for the event timer core
module mcet_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_kind,
    input logic [7:0]  o_fired_id,
    input logic [31:0] o_fire_count,
    input logic [4:0]  o_timer_count,
    input logic [1:0]  o_status,
    input logic        o_last
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_fired_id) && $stable(o_last))
        else $error("stalled item changed");
    a_last_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last == o_kind))
        else $error("last differs from kind");
    a_fire_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_kind |-> o_fire_count != 32'd0 && o_timer_count == 5'd0)
        else $error("bad expiry item");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> o_stall)
        else $error("input taken mid command");
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind |-> o_status != 2'd3)
        else $error("bad status code");
endmodule

bind multi_channel_event_timer_core mcet_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_kind(o_kind), .o_fired_id(o_fired_id),
    .o_fire_count(o_fire_count), .o_timer_count(o_timer_count),
    .o_status(o_status), .o_last(o_last)
);
